FILE: design/uv_sphere_vertex_generator_top_defines.svh
// Assertion helpers used by the checker file.
`ifndef UV_SPHERE_VERTEX_GENERATOR_TOP_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define UVS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define UVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/uvs_pkg.sv
`timescale 1ns / 1ps
package uvs_pkg;

  localparam int CNT_W = 11;
  localparam int Q_W   = 33;
  localparam int CORDIC_STEPS = 24;
  localparam int FRAC_STEPS   = 32;

  localparam logic [CNT_W-1:0] SECTOR_MIN = 11'd3;
  localparam logic [CNT_W-1:0] STACK_MIN  = 11'd2;
  localparam logic [CNT_W-1:0] SECTOR_RESET = 11'd36;
  localparam logic [CNT_W-1:0] STACK_RESET  = 11'd18;

  // Register decode on paddr[2]
  localparam logic REG_SECTOR = 1'b0;
  localparam logic REG_STACK  = 1'b1;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  typedef struct packed {
    logic [CNT_W-1:0] stack_index;
    logic [CNT_W-1:0] sector_index;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               index_error;
  } out_item_t;

  // One stage of the long-division chain (sector and stack side by side)
  typedef struct packed {
    logic             valid;
    logic             err;
    logic [Q_W-1:0]   qs;
    logic [Q_W-1:0]   qt;
    logic [CNT_W-1:0] rs;
    logic [CNT_W-1:0] rt;
    logic [CNT_W-1:0] rs16;
    logic [CNT_W-1:0] rt16;
    logic [CNT_W-1:0] rt31;
  } div_t;

  // One stage of the rotation chain (stack and sector angle side by side)
  typedef struct packed {
    logic               valid;
    logic               err;
    logic               flip_s;
    logic               flip_t;
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    logic signed [31:0] zs;
    logic signed [31:0] xt;
    logic signed [31:0] yt;
    logic signed [31:0] zt;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
  } cor_t;

  // Arctangent of 2^-k in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int unsigned k);
    case (k)
      0:  return 32'h20000000;
      1:  return 32'h12E4051E;
      2:  return 32'h09FB385B;
      3:  return 32'h051111D4;
      4:  return 32'h028B0D43;
      5:  return 32'h0145D7E1;
      6:  return 32'h00A2F61E;
      7:  return 32'h00517C55;
      8:  return 32'h0028BE53;
      9:  return 32'h00145F2F;
      10: return 32'h000A2F98;
      11: return 32'h000517CC;
      12: return 32'h00028BE6;
      13: return 32'h000145F3;
      14: return 32'h0000A2FA;
      15: return 32'h0000517D;
      16: return 32'h000028BE;
      17: return 32'h0000145F;
      18: return 32'h00000A30;
      19: return 32'h00000518;
      20: return 32'h0000028C;
      21: return 32'h00000146;
      22: return 32'h000000A3;
      23: return 32'h00000051;
      default: return 32'h0;
    endcase
  endfunction

  // Clip a rounded value to signed 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) return 16'sd32767;
    else if (v < -19'sd32768) return -16'sd32768;
    else return v[15:0];
  endfunction

endpackage

FILE: design/uv_sphere_vertex_generator_top.sv
`timescale 1ns / 1ps
// UV sphere vertex generator: one lattice point in, one vertex out.
// Pipeline: the input stage loads at the accepting edge, then 32 division cells, phase,
// 24 rotation cells, sign, multiply and output registers lead to the result strobe.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the pipeline and loads counts 36 and 18.
module uv_sphere_vertex_generator_top import uvs_pkg::*; #(
  parameter int MAX_DIVISIONS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_strobe,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CNT_W-1:0] sector_count_r;
  logic [CNT_W-1:0] stack_count_r;
  logic [CNT_W-1:0] n_cnt;
  logic [CNT_W-1:0] st_cnt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_count_r <= SECTOR_RESET;
      stack_count_r  <= STACK_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_SECTOR: sector_count_r <= pwdata[CNT_W-1:0];
        REG_STACK:  stack_count_r  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_STACK) ? {{(32-CNT_W){1'b0}}, stack_count_r}
                                          : {{(32-CNT_W){1'b0}}, sector_count_r};
  assign pready = 1'b1;
  assign busy   = 1'b0;

  // Clamp counts into their legal range
  always_comb begin
    if (sector_count_r < SECTOR_MIN) n_cnt = SECTOR_MIN;
    else if (32'(sector_count_r) > 32'(MAX_DIVISIONS)) n_cnt = CNT_W'(MAX_DIVISIONS);
    else n_cnt = sector_count_r;
    if (stack_count_r < STACK_MIN) st_cnt = STACK_MIN;
    else if (32'(stack_count_r) > 32'(MAX_DIVISIONS)) st_cnt = CNT_W'(MAX_DIVISIONS);
    else st_cnt = stack_count_r;
  end

  // Input stage: range check and integer quotient bit
  div_t div_c [0:FRAC_STEPS];
  div_t in_nxt;
  logic int_s;
  logic int_t;

  always_comb begin
    int_s = in_item.sector_index >= n_cnt;
    int_t = in_item.stack_index >= st_cnt;
    in_nxt       = '0;
    in_nxt.valid = start && !busy;
    in_nxt.err   = (in_item.stack_index > st_cnt) || (in_item.sector_index > n_cnt);
    in_nxt.qs    = {{(Q_W-1){1'b0}}, int_s};
    in_nxt.qt    = {{(Q_W-1){1'b0}}, int_t};
    in_nxt.rs    = int_s ? in_item.sector_index - n_cnt : in_item.sector_index;
    in_nxt.rt    = int_t ? in_item.stack_index - st_cnt : in_item.stack_index;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_c[0] <= '0;
    end else begin
      div_c[0] <= in_nxt;
    end
  end

  // Long division, one fraction bit per cell
  for (genvar k = 1; k <= FRAC_STEPS; k++) begin : g_div
    uvs_div_cell #(.K(k)) u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .n_cnt  (n_cnt),
      .st_cnt (st_cnt),
      .d_in   (div_c[k-1]),
      .d_out  (div_c[k])
    );
  end

  // Phase stage: round quotients to phases and texture coordinates
  div_t             dq;
  logic [CNT_W-1:0] hs;
  logic [CNT_W-1:0] ht;
  logic             inc_s;
  logic             inc_t;
  logic             inc_u;
  logic             inc_v;
  logic             ph_valid_r;
  logic             ph_err_r;
  logic [31:0]      ph_s_r;
  logic [31:0]      ph_t_r;
  logic [16:0]      ph_u_r;
  logic [16:0]      ph_v_r;

  always_comb begin
    dq    = div_c[FRAC_STEPS];
    hs    = n_cnt >> 1;
    ht    = st_cnt >> 1;
    inc_s = ({1'b0, dq.rs}   + {1'b0, hs}) >= {1'b0, n_cnt};
    inc_u = ({1'b0, dq.rs16} + {1'b0, hs}) >= {1'b0, n_cnt};
    inc_t = ({1'b0, dq.rt31} + {1'b0, ht}) >= {1'b0, st_cnt};
    inc_v = ({1'b0, dq.rt16} + {1'b0, ht}) >= {1'b0, st_cnt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_valid_r <= 1'b0;
    end else begin
      ph_valid_r <= dq.valid;
    end
  end

  always_ff @(posedge clk) begin
    ph_err_r <= dq.err;
    ph_s_r   <= dq.qs[31:0] + 32'(inc_s);
    ph_t_r   <= dq.qt[32:1] + 32'(inc_t);
    ph_u_r   <= dq.qs[32:16] + 17'(inc_u);
    ph_v_r   <= dq.qt[32:16] + 17'(inc_v);
  end

  // Fold phases into the right half-plane and seed the rotation
  cor_t        cor_c [0:CORDIC_STEPS];
  logic [31:0] fold_s;
  logic [31:0] fold_t;

  always_comb begin
    fold_s = ph_s_r + 32'h4000_0000;
    fold_t = ph_t_r + 32'h4000_0000;
    cor_c[0].valid  = ph_valid_r;
    cor_c[0].err    = ph_err_r;
    cor_c[0].flip_s = fold_s[31];
    cor_c[0].flip_t = fold_t[31];
    cor_c[0].xs     = CORDIC_GAIN;
    cor_c[0].ys     = '0;
    cor_c[0].zs     = fold_s[31] ? (ph_s_r ^ 32'h8000_0000) : ph_s_r;
    cor_c[0].xt     = CORDIC_GAIN;
    cor_c[0].yt     = '0;
    cor_c[0].zt     = fold_t[31] ? (ph_t_r ^ 32'h8000_0000) : ph_t_r;
    cor_c[0].tex_u  = ph_u_r;
    cor_c[0].tex_v  = ph_v_r;
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cor
    uvs_cordic_cell #(.K(k)) u_cor (
      .clk   (clk),
      .rst_n (rst_n),
      .c_in  (cor_c[k]),
      .c_out (cor_c[k+1])
    );
  end

  // Sign stage: undo the fold
  cor_t               cf;
  logic               sg_valid_r;
  logic               sg_err_r;
  logic signed [31:0] sg_xy_r;
  logic signed [31:0] sg_zc_r;
  logic signed [31:0] sg_ss_r;
  logic signed [31:0] sg_sc_r;
  logic [16:0]        sg_u_r;
  logic [16:0]        sg_v_r;

  assign cf = cor_c[CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sg_valid_r <= 1'b0;
    end else begin
      sg_valid_r <= cf.valid;
    end
  end

  always_ff @(posedge clk) begin
    sg_err_r <= cf.err;
    sg_xy_r  <= cf.flip_t ? -cf.yt : cf.yt;
    sg_zc_r  <= cf.flip_t ? -cf.xt : cf.xt;
    sg_ss_r  <= cf.flip_s ? -cf.ys : cf.ys;
    sg_sc_r  <= cf.flip_s ? -cf.xs : cf.xs;
    sg_u_r   <= cf.tex_u;
    sg_v_r   <= cf.tex_v;
  end

  // Multiply stage: ring radius times sector cosine and sine
  logic               mu_valid_r;
  logic               mu_err_r;
  logic signed [63:0] mu_px_r;
  logic signed [63:0] mu_py_r;
  logic signed [31:0] mu_zc_r;
  logic [16:0]        mu_u_r;
  logic [16:0]        mu_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_valid_r <= 1'b0;
    end else begin
      mu_valid_r <= sg_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    mu_err_r <= sg_err_r;
    mu_px_r  <= sg_xy_r * sg_sc_r;
    mu_py_r  <= sg_xy_r * sg_ss_r;
    mu_zc_r  <= sg_zc_r;
    mu_u_r   <= sg_u_r;
    mu_v_r   <= sg_v_r;
  end

  // Output stage: round, saturate, zero on index error
  logic signed [63:0] rx;
  logic signed [63:0] ry;
  logic signed [32:0] rz;
  out_item_t          out_nxt;
  out_item_t          out_item_r;
  logic               out_strobe_r;

  always_comb begin
    rx = mu_px_r + (64'sd1 <<< 44);
    ry = mu_py_r + (64'sd1 <<< 44);
    rz = {mu_zc_r[31], mu_zc_r} + 33'sd16384;
    out_nxt = '0;
    if (mu_err_r) begin
      out_nxt.index_error = 1'b1;
    end else begin
      out_nxt.pos_x = sat16(rx[63:45]);
      out_nxt.pos_y = sat16(ry[63:45]);
      out_nxt.pos_z = sat16({rz[32], rz[32:15]});
      out_nxt.tex_u = mu_u_r;
      out_nxt.tex_v = mu_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= mu_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

FILE: design/uvs_div_cell.sv
`timescale 1ns / 1ps
module uvs_div_cell import uvs_pkg::*; #(
  parameter int K = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] n_cnt,
  input  logic [CNT_W-1:0] st_cnt,
  input  div_t             d_in,
  output div_t             d_out
);

  div_t             d_nxt;
  div_t             d_r;
  logic [CNT_W:0]   rs2;
  logic [CNT_W:0]   rt2;
  logic             bs;
  logic             bt;

  // Produce one quotient bit per axis
  always_comb begin
    rs2 = {d_in.rs, 1'b0};
    rt2 = {d_in.rt, 1'b0};
    bs  = rs2 >= {1'b0, n_cnt};
    bt  = rt2 >= {1'b0, st_cnt};
    d_nxt    = d_in;
    d_nxt.qs = {d_in.qs[Q_W-2:0], bs};
    d_nxt.qt = {d_in.qt[Q_W-2:0], bt};
    d_nxt.rs = bs ? CNT_W'(rs2 - {1'b0, n_cnt}) : rs2[CNT_W-1:0];
    d_nxt.rt = bt ? CNT_W'(rt2 - {1'b0, st_cnt}) : rt2[CNT_W-1:0];
    // Snapshot remainders where the shorter quotients end
    if (K == 16) begin
      d_nxt.rs16 = d_nxt.rs;
      d_nxt.rt16 = d_nxt.rt;
    end
    if (K == 31) begin
      d_nxt.rt31 = d_nxt.rt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
    end else begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

FILE: design/uvs_cordic_cell.sv
`timescale 1ns / 1ps
module uvs_cordic_cell import uvs_pkg::*; #(
  parameter int K = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  cor_t c_in,
  output cor_t c_out
);

  localparam logic signed [31:0] ATAN = atan_turn(K);

  cor_t               c_nxt;
  cor_t               c_r;
  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic signed [31:0] xt;
  logic signed [31:0] yt;

  // Rotate both vectors one micro-step toward their residual angle
  always_comb begin
    xs = c_in.xs;
    ys = c_in.ys;
    xt = c_in.xt;
    yt = c_in.yt;
    c_nxt = c_in;
    if (!c_in.zs[31]) begin
      c_nxt.xs = xs - (ys >>> K);
      c_nxt.ys = ys + (xs >>> K);
      c_nxt.zs = c_in.zs - ATAN;
    end else begin
      c_nxt.xs = xs + (ys >>> K);
      c_nxt.ys = ys - (xs >>> K);
      c_nxt.zs = c_in.zs + ATAN;
    end
    if (!c_in.zt[31]) begin
      c_nxt.xt = xt - (yt >>> K);
      c_nxt.yt = yt + (xt >>> K);
      c_nxt.zt = c_in.zt - ATAN;
    end else begin
      c_nxt.xt = xt + (yt >>> K);
      c_nxt.yt = yt - (xt >>> K);
      c_nxt.zt = c_in.zt + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r <= '0;
    end else begin
      c_r <= c_nxt;
    end
  end

  assign c_out = c_r;

endmodule

FILE: design/uvs_checker.sv
`timescale 1ns / 1ps
`include "uv_sphere_vertex_generator_top_defines.svh"
module uvs_checker import uvs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      busy,
  input logic      out_strobe,
  input out_item_t out_item
);

  // The block never pushes back
  `UVS_ASSERT_IMPL(a_no_busy, 1'b1, !busy, "busy raised")

  // An index error zeroes every other field
  `UVS_ASSERT_IMPL(a_err_zero, out_strobe && out_item.index_error, (out_item.pos_x == 16'sd0) && (out_item.pos_y == 16'sd0) && (out_item.pos_z == 16'sd0) && (out_item.tex_u == 17'd0) && (out_item.tex_v == 17'd0), "error item carries data")

  // Texture coordinates never pass one
  `UVS_ASSERT_IMPL(a_tex_range, out_strobe, (out_item.tex_u <= 17'd65536) && (out_item.tex_v <= 17'd65536), "texture coordinate above one")

  // The north pole sits at the top
  `UVS_ASSERT_IMPL(a_pole, out_strobe && !out_item.index_error && (out_item.tex_v == 17'd0), out_item.pos_z >= 16'sd32760, "north pole not at top")

endmodule

bind uv_sphere_vertex_generator_top uvs_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
